[rtl/name_intern_table_top_defines.svh]
// Assertion macros shared by the name intern table checkers.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef NAME_INTERN_TABLE_TOP_DEFINES_SVH
`define NAME_INTERN_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NIT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NIT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nit_pkg.sv]
// Name intern table package: widths, codes, hash constants, FSM types
// and the controller/datapath command and status structs. No dependencies.
package nit_pkg;

    localparam int SLOT_COUNT_DEFAULT     = 1024;
    localparam int MAX_NAME_WORDS_DEFAULT = 8;

    localparam int WORD_W  = 64;
    localparam int BYTES_W = 4;
    localparam int ID_W    = 9;
    localparam int STAT_W  = 2;
    localparam int TAG_W   = 32;

    localparam logic [63:0] MIX_MUL  = 64'h9FB21C651E98DF25;
    localparam logic [63:0] MIX_SEED = 64'h9E3779B97F4A7C15;
    localparam int ROUND_SHIFT = 32;
    localparam int FINAL_SHIFT = 29;

    localparam logic CMD_INTERN = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_RLEN,
        ST_RDATA,
        ST_HASH,
        ST_PROBE,
        ST_SLOT,
        ST_TLEN,
        ST_CMP,
        ST_INS,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RES_TOO_LONG,
        RES_EMPTY,
        RES_FULL,
        RES_FOUND,
        RES_NEW
    } res_sel_t;

    // hash multiply phases: three 32x32 partial products, then the sum
    typedef enum logic [1:0] {
        PH_XOR_LO,
        PH_HI_LO,
        PH_LO_HI,
        PH_SUM
    } hash_ph_t;

    typedef struct packed {
        logic     clr_step;
        logic     buf_write;
        logic     rd_start;
        logic     rd_len;
        logic     rd_emit;
        logic     rd_empty_emit;
        logic     hash_start;
        logic     hash_run;
        logic     probe_read;
        logic     probe_next;
        logic     tlen_read;
        logic     cmp_start;
        logic     cmp_next;
        logic     widx_clr;
        logic     ins_write;
        logic     ins_commit;
        logic     res_set;
        res_sel_t res_sel;
        logic     emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic buf_over;
        logic buf_empty;
        logic rd_len_zero;
        logic rd_last;
        logic hash_done;
        logic slot_empty;
        logic tag_hit;
        logic table_full;
        logic len_match;
        logic word_match;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/nit_req_if.sv]
// Request channel of the name intern table: valid/ready plus payload.
// Depends on nit_pkg.
interface nit_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [nit_pkg::WORD_W-1:0]   name_word;
    logic [nit_pkg::BYTES_W-1:0]  word_bytes;
    logic                         word_last;
    logic [nit_pkg::ID_W-1:0]     read_id;

    modport source (output valid, cmd, name_word, word_bytes, word_last, read_id,
                    input ready);
    modport sink   (input valid, cmd, name_word, word_bytes, word_last, read_id,
                    output ready);
endinterface

[rtl/nit_rsp_if.sv]
// Result channel of the name intern table: valid/ready plus payload.
// Depends on nit_pkg.
interface nit_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [nit_pkg::ID_W-1:0]     result_id;
    logic [nit_pkg::STAT_W-1:0]   status;
    logic                         is_new;
    logic [nit_pkg::WORD_W-1:0]   text_word;
    logic [nit_pkg::BYTES_W-1:0]  text_bytes;
    logic                         text_last;

    modport source (output valid, result_id, status, is_new, text_word, text_bytes,
                    text_last, input ready);
    modport sink   (input valid, result_id, status, is_new, text_word, text_bytes,
                    text_last, output ready);
endinterface

[rtl/nit_ctrl.sv]
// Name intern table controller: sequences clear, buffering, hash, probe,
// compare, insert and read-back. Depends on nit_pkg.
module nit_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    input  logic              in_last,
    input  nit_pkg::dp_stat_t stat,
    output logic              in_ready,
    output nit_pkg::ctl_cmd_t cmd
);

    nit_pkg::state_t state_reg;
    nit_pkg::state_t state_next;
    logic            accept;

    assign in_ready = (state_reg == nit_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nit_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nit_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = nit_pkg::ST_IDLE;
            end
            nit_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == nit_pkg::CMD_READ)
                        state_next = nit_pkg::ST_RLEN;
                    else if (in_last)
                        state_next = nit_pkg::ST_DECIDE;
                end
            end
            nit_pkg::ST_DECIDE:
            begin
                if (stat.buf_over || stat.buf_empty)
                    state_next = nit_pkg::ST_EMIT;
                else
                    state_next = nit_pkg::ST_HASH;
            end
            nit_pkg::ST_HASH:
            begin
                if (stat.hash_done)
                    state_next = nit_pkg::ST_PROBE;
            end
            nit_pkg::ST_PROBE:
            begin
                state_next = nit_pkg::ST_SLOT;
            end
            nit_pkg::ST_SLOT:
            begin
                if (stat.slot_empty)
                    state_next = stat.table_full ? nit_pkg::ST_EMIT : nit_pkg::ST_INS;
                else if (stat.tag_hit)
                    state_next = nit_pkg::ST_TLEN;
                else
                    state_next = nit_pkg::ST_PROBE;
            end
            nit_pkg::ST_TLEN:
            begin
                state_next = stat.len_match ? nit_pkg::ST_CMP : nit_pkg::ST_PROBE;
            end
            nit_pkg::ST_CMP:
            begin
                if (!stat.word_match)
                    state_next = nit_pkg::ST_PROBE;
                else if (stat.idx_last)
                    state_next = nit_pkg::ST_EMIT;
            end
            nit_pkg::ST_INS:
            begin
                if (stat.idx_last)
                    state_next = nit_pkg::ST_EMIT;
            end
            nit_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = nit_pkg::ST_IDLE;
            end
            nit_pkg::ST_RLEN:
            begin
                if (!stat.rd_len_zero)
                    state_next = nit_pkg::ST_RDATA;
                else if (stat.out_free)
                    state_next = nit_pkg::ST_IDLE;
            end
            nit_pkg::ST_RDATA:
            begin
                if (stat.out_free && stat.rd_last)
                    state_next = nit_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nit_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.res_sel = nit_pkg::RES_EMPTY;
        case (state_reg)
            nit_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            nit_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == nit_pkg::CMD_READ)
                        cmd.rd_start = 1'b1;
                    else
                        cmd.buf_write = 1'b1;
                end
            end
            nit_pkg::ST_DECIDE:
            begin
                if (stat.buf_over)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = nit_pkg::RES_TOO_LONG;
                end
                else if (stat.buf_empty)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = nit_pkg::RES_EMPTY;
                end
                else
                begin
                    cmd.hash_start = 1'b1;
                end
            end
            nit_pkg::ST_HASH:
            begin
                cmd.hash_run = 1'b1;
            end
            nit_pkg::ST_PROBE:
            begin
                cmd.probe_read = 1'b1;
            end
            nit_pkg::ST_SLOT:
            begin
                if (stat.slot_empty)
                begin
                    if (stat.table_full)
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = nit_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.widx_clr = 1'b1;
                    end
                end
                else if (stat.tag_hit)
                begin
                    cmd.tlen_read = 1'b1;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            nit_pkg::ST_TLEN:
            begin
                if (stat.len_match)
                    cmd.cmp_start = 1'b1;
                else
                    cmd.probe_next = 1'b1;
            end
            nit_pkg::ST_CMP:
            begin
                if (!stat.word_match)
                begin
                    cmd.probe_next = 1'b1;
                end
                else if (stat.idx_last)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = nit_pkg::RES_FOUND;
                end
                else
                begin
                    cmd.cmp_next = 1'b1;
                end
            end
            nit_pkg::ST_INS:
            begin
                cmd.ins_write = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.ins_commit = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_sel    = nit_pkg::RES_NEW;
                end
            end
            nit_pkg::ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            nit_pkg::ST_RLEN:
            begin
                if (!stat.rd_len_zero)
                    cmd.rd_len = 1'b1;
                else
                    cmd.rd_empty_emit = stat.out_free;
            end
            nit_pkg::ST_RDATA:
            begin
                cmd.rd_emit = stat.out_free;
            end
            default:
            begin
                cmd.res_sel = nit_pkg::RES_EMPTY;
            end
        endcase
    end

endmodule

[rtl/nit_datapath.sv]
// Name intern table datapath: name buffer, shared-multiplier hash, slot
// table, text store, length table and result register. Depends on nit_pkg.
module nit_datapath #(
    parameter int SLOT_COUNT     = nit_pkg::SLOT_COUNT_DEFAULT,
    parameter int MAX_NAME_WORDS = nit_pkg::MAX_NAME_WORDS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nit_pkg::ctl_cmd_t             cmd,
    output nit_pkg::dp_stat_t             stat,
    input  logic [nit_pkg::WORD_W-1:0]    in_word,
    input  logic [nit_pkg::BYTES_W-1:0]   in_bytes,
    input  logic [nit_pkg::ID_W-1:0]      in_read_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nit_pkg::ID_W-1:0]      out_result_id,
    output logic [nit_pkg::STAT_W-1:0]    out_status,
    output logic                          out_is_new,
    output logic [nit_pkg::WORD_W-1:0]    out_text_word,
    output logic [nit_pkg::BYTES_W-1:0]   out_text_bytes,
    output logic                          out_text_last
);

    localparam int SLOTW       = $clog2(SLOT_COUNT);
    localparam int IW          = SLOTW - 1;
    localparam int MAX_ENTRIES = SLOT_COUNT / 2;
    localparam int MAX_BYTES   = 8 * MAX_NAME_WORDS;
    localparam int BBW         = $clog2(MAX_BYTES + 1);
    localparam int KW          = BBW - 3;
    localparam int WIW         = (MAX_NAME_WORDS > 1) ? $clog2(MAX_NAME_WORDS) : 1;
    localparam int CW          = (SLOTW > nit_pkg::ID_W) ? SLOTW : nit_pkg::ID_W;
    localparam int SW          = nit_pkg::TAG_W + SLOTW;
    localparam int TXD         = MAX_ENTRIES << WIW;

    // storage
    logic [SW-1:0]  slot_mem [SLOT_COUNT];
    logic [63:0]    text_mem [TXD];
    logic [BBW-1:0] tlen_mem [MAX_ENTRIES];
    logic [63:0]    name_buf_reg [MAX_NAME_WORDS];

    logic [SW-1:0]  slot_q_reg;
    logic [63:0]    text_q_reg;
    logic [BBW-1:0] tlen_q_reg;

    // control state
    logic [SLOTW-1:0]  clr_idx_reg;
    logic [BBW-1:0]    bb_reg;
    logic              over_reg;
    logic [SLOTW-1:0]  ec_reg;
    nit_pkg::hash_ph_t ph_reg;
    logic              hfin_reg;
    logic [WIW-1:0]    widx_reg;
    logic              out_valid_reg;

    // payload state
    logic [63:0]       h_reg, a_reg, p0_reg;
    logic [31:0]       p1_reg, p2_reg;
    logic [SLOTW-1:0]  at_reg;
    logic [31:0]       tag_reg;
    logic [IW-1:0]     hit_id_reg;
    logic [nit_pkg::ID_W-1:0] rid_reg;
    logic              rid_ok_reg;
    logic [BBW-1:0]    rlen_reg;
    logic [nit_pkg::ID_W-1:0]   res_id_reg;
    logic [nit_pkg::STAT_W-1:0] res_status_reg;
    logic              res_new_reg;
    logic [nit_pkg::ID_W-1:0]   out_id_reg;
    logic [nit_pkg::STAT_W-1:0] out_status_reg;
    logic              out_new_reg;
    logic [63:0]       out_word_reg;
    logic [nit_pkg::BYTES_W-1:0] out_bytes_reg;
    logic              out_last_reg;

    // buffer packing
    logic [nit_pkg::BYTES_W-1:0] nb_sat;
    logic [BBW-1:0]    room, take, bb_next;
    logic              over_set;
    logic [63:0]       masked;
    logic [2:0]        boff;
    logic [KW-1:0]     bk;
    logic [127:0]      shifted;
    logic [WIW-1:0]    bsel;
    logic [63:0]       bq;
    logic [BBW-1:0]    nwb;

    // hash
    logic [63:0]       a_in, mul_p, sum, h_round, h_final;
    logic [31:0]       mul_x, mul_y;

    // probe / read
    logic [IW-1:0]     slot_id, ec_id, rid_ix, tl_raddr, tx_rid;
    logic [WIW-1:0]    widx_inc, tx_rw;
    logic              tx_ren, tl_ren, load_out;
    logic [BBW-1:0]    rlen_now, rem;
    logic              rid_ok_now;
    logic [SLOTW-1:0]  slot_idp;

    assign nb_sat   = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
    assign room     = BBW'(MAX_BYTES) - bb_reg;
    assign over_set = BBW'(nb_sat) > room;
    assign take     = over_set ? room : BBW'(nb_sat);
    assign bb_next  = bb_reg + take;
    assign boff     = bb_reg[2:0];
    assign bk       = bb_reg[BBW-1:3];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            masked[i*8 +: 8] = (BBW'(i) < take) ? in_word[i*8 +: 8] : 8'h00;
        end
    end

    assign shifted = {64'd0, masked} << {boff, 3'b000};
    assign bsel    = cmd.buf_write ? WIW'(bk) : widx_reg;
    assign bq      = name_buf_reg[bsel];
    assign nwb     = BBW'((bb_reg + BBW'(7)) >> 3);

    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
        begin
            if (int'(bk) < MAX_NAME_WORDS)
                name_buf_reg[WIW'(bk)] <= (boff == 3'd0) ? shifted[63:0]
                                                         : (bq | shifted[63:0]);
            if (int'(bk) + 1 < MAX_NAME_WORDS)
                name_buf_reg[WIW'(bk + KW'(1))] <= shifted[127:64];
        end
    end

    // hash: one shared 32x32 multiplier, four phases per round
    assign a_in = hfin_reg ? h_reg : (h_reg ^ bq);

    always_comb
    begin
        case (ph_reg)
            nit_pkg::PH_XOR_LO: mul_x = a_in[31:0];
            nit_pkg::PH_HI_LO:  mul_x = a_reg[63:32];
            default:            mul_x = a_reg[31:0];
        endcase
    end

    assign mul_y   = (ph_reg == nit_pkg::PH_LO_HI) ? nit_pkg::MIX_MUL[63:32]
                                                  : nit_pkg::MIX_MUL[31:0];
    assign mul_p   = 64'(mul_x) * 64'(mul_y);
    assign sum     = p0_reg + {p1_reg + p2_reg, 32'd0};
    assign h_round = sum ^ (sum >> nit_pkg::ROUND_SHIFT);
    assign h_final = sum ^ (sum >> nit_pkg::FINAL_SHIFT);

    // ids and addresses
    assign slot_idp   = slot_q_reg[SLOTW-1:0];
    assign slot_id    = IW'(slot_idp - SLOTW'(1));
    assign ec_id      = IW'(ec_reg);
    assign rid_ix     = IW'(rid_reg);
    assign widx_inc   = widx_reg + WIW'(1);
    assign tl_raddr   = cmd.rd_start ? IW'(in_read_id) : slot_id;
    assign tl_ren     = cmd.rd_start || cmd.tlen_read;
    assign tx_rid     = (cmd.rd_len || cmd.rd_emit) ? rid_ix : hit_id_reg;
    assign tx_rw      = (cmd.rd_len || cmd.cmp_start) ? '0 : widx_inc;
    assign tx_ren     = cmd.rd_len || cmd.rd_emit || cmd.cmp_start || cmd.cmp_next;
    assign rid_ok_now = (in_read_id != '0) && (CW'(in_read_id) < CW'(ec_reg));
    assign rlen_now   = rid_ok_reg ? tlen_q_reg : '0;
    assign rem        = rlen_reg - BBW'({widx_reg, 3'b000});
    assign load_out   = cmd.emit || cmd.rd_emit || cmd.rd_empty_emit;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            slot_mem[clr_idx_reg] <= '0;
        else if (cmd.ins_commit)
            slot_mem[at_reg] <= {tag_reg, ec_reg + SLOTW'(1)};
        if (cmd.probe_read)
            slot_q_reg <= slot_mem[at_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
            text_mem[{ec_id, widx_reg}] <= bq;
        if (tx_ren)
            text_q_reg <= text_mem[{tx_rid, tx_rw}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_commit)
            tlen_mem[ec_id] <= bb_reg;
        if (tl_ren)
            tlen_q_reg <= tlen_mem[tl_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            bb_reg        <= '0;
            over_reg      <= 1'b0;
            ec_reg        <= SLOTW'(1);
            ph_reg        <= nit_pkg::PH_XOR_LO;
            hfin_reg      <= 1'b0;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_idx_reg <= clr_idx_reg + SLOTW'(1);

            if (cmd.buf_write)
            begin
                bb_reg   <= bb_next;
                over_reg <= over_reg | over_set;
            end
            else if (cmd.emit)
            begin
                bb_reg   <= '0;
                over_reg <= 1'b0;
            end

            if (cmd.ins_commit)
                ec_reg <= ec_reg + SLOTW'(1);

            if (cmd.hash_start)
            begin
                ph_reg   <= nit_pkg::PH_XOR_LO;
                hfin_reg <= 1'b0;
            end
            else if (cmd.hash_run)
            begin
                case (ph_reg)
                    nit_pkg::PH_XOR_LO: ph_reg <= nit_pkg::PH_HI_LO;
                    nit_pkg::PH_HI_LO:  ph_reg <= nit_pkg::PH_LO_HI;
                    nit_pkg::PH_LO_HI:  ph_reg <= nit_pkg::PH_SUM;
                    default:
                    begin
                        ph_reg <= nit_pkg::PH_XOR_LO;
                        if (stat.idx_last)
                            hfin_reg <= 1'b1;
                    end
                endcase
            end

            if (cmd.hash_start || cmd.widx_clr || cmd.rd_len || cmd.cmp_start)
                widx_reg <= '0;
            else if (cmd.rd_emit || cmd.cmp_next || cmd.ins_write)
                widx_reg <= widx_inc;
            else if (cmd.hash_run && ph_reg == nit_pkg::PH_SUM && !hfin_reg
                     && !stat.idx_last)
                widx_reg <= widx_inc;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.hash_start)
        begin
            h_reg <= nit_pkg::MIX_SEED ^ 64'(bb_reg);
        end
        else if (cmd.hash_run)
        begin
            case (ph_reg)
                nit_pkg::PH_XOR_LO:
                begin
                    a_reg  <= a_in;
                    p0_reg <= mul_p;
                end
                nit_pkg::PH_HI_LO: p1_reg <= mul_p[31:0];
                nit_pkg::PH_LO_HI: p2_reg <= mul_p[31:0];
                default:
                begin
                    if (hfin_reg)
                    begin
                        h_reg   <= h_final;
                        at_reg  <= h_final[SLOTW-1:0];
                        tag_reg <= h_final[63:32];
                    end
                    else
                    begin
                        h_reg <= h_round;
                    end
                end
            endcase
        end

        if (cmd.probe_next)
            at_reg <= at_reg + SLOTW'(1);
        if (cmd.tlen_read)
            hit_id_reg <= slot_id;

        if (cmd.rd_start)
        begin
            rid_reg    <= in_read_id;
            rid_ok_reg <= rid_ok_now;
        end
        if (cmd.rd_len)
            rlen_reg <= rlen_now;

        if (cmd.res_set)
        begin
            case (cmd.res_sel)
                nit_pkg::RES_TOO_LONG:
                begin
                    res_id_reg     <= '0;
                    res_status_reg <= nit_pkg::STATUS_TOO_LONG;
                    res_new_reg    <= 1'b0;
                end
                nit_pkg::RES_FULL:
                begin
                    res_id_reg     <= '0;
                    res_status_reg <= nit_pkg::STATUS_FULL;
                    res_new_reg    <= 1'b0;
                end
                nit_pkg::RES_FOUND:
                begin
                    res_id_reg     <= nit_pkg::ID_W'(hit_id_reg);
                    res_status_reg <= nit_pkg::STATUS_OK;
                    res_new_reg    <= 1'b0;
                end
                nit_pkg::RES_NEW:
                begin
                    res_id_reg     <= nit_pkg::ID_W'(ec_reg);
                    res_status_reg <= nit_pkg::STATUS_OK;
                    res_new_reg    <= 1'b1;
                end
                default:
                begin
                    res_id_reg     <= '0;
                    res_status_reg <= nit_pkg::STATUS_OK;
                    res_new_reg    <= 1'b0;
                end
            endcase
        end

        if (cmd.emit)
        begin
            out_id_reg     <= res_id_reg;
            out_status_reg <= res_status_reg;
            out_new_reg    <= res_new_reg;
            out_word_reg   <= '0;
            out_bytes_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.rd_empty_emit || cmd.rd_emit)
        begin
            out_id_reg     <= rid_reg;
            out_status_reg <= nit_pkg::STATUS_OK;
            out_new_reg    <= 1'b0;
            out_word_reg   <= cmd.rd_emit ? text_q_reg : '0;
            out_bytes_reg  <= !cmd.rd_emit ? '0
                            : (stat.rd_last ? nit_pkg::BYTES_W'(rem) : 4'd8);
            out_last_reg   <= cmd.rd_emit ? stat.rd_last : 1'b1;
        end
    end

    // status
    always_comb
    begin
        stat             = '0;
        stat.clr_last    = (clr_idx_reg == '1);
        stat.buf_over    = over_reg;
        stat.buf_empty   = (bb_reg == '0);
        stat.rd_len_zero = (rlen_now == '0);
        stat.rd_last     = (rem <= BBW'(8));
        stat.hash_done   = (ph_reg == nit_pkg::PH_SUM) && hfin_reg;
        stat.slot_empty  = (slot_idp == '0);
        stat.tag_hit     = (slot_q_reg[SW-1:SLOTW] == tag_reg);
        stat.table_full  = (ec_reg >= SLOTW'(MAX_ENTRIES));
        stat.len_match   = (tlen_q_reg == bb_reg);
        stat.word_match  = (text_q_reg == bq);
        stat.idx_last    = ((BBW'(widx_reg) + BBW'(1)) == nwb);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_result_id  = out_id_reg;
    assign out_status     = out_status_reg;
    assign out_is_new     = out_new_reg;
    assign out_text_word  = out_word_reg;
    assign out_text_bytes = out_bytes_reg;
    assign out_text_last  = out_last_reg;

endmodule

[rtl/name_intern_table_top.sv]
// Name intern table top level: joins controller and datapath to the
// request and result channels. Depends on nit_pkg, nit_req_if, nit_rsp_if.
//
// Interns names and hands out dense ids (id 0 is the empty name). An intern
// name arrives as cmd=0 requests, one 8-byte word each, word_last on the final
// one; a non-final word is buffered and gives no result. On the final word the
// block hashes the buffered name (seed xor length, multiply-xor per word, final
// avalanche), probes the slot table linearly from the low hash bits, checks
// tag, then stored length, then stored words, and returns one result: existing
// id, new id (is_new=1), status 1 when adding would pass half the slot count,
// or status 2 when the name is longer than MAX_NAME_WORDS*8 bytes. A cmd=1
// request streams back the stored words of read_id, text_last on the final
// word; an unknown id reads as the empty name (one result, zero bytes). The
// hash shares one 32x32 multiplier over nw+1 rounds (nw = name words); each
// probed slot is read and then checked, a tag hit adds a length read and then
// a compare per stored word; an insert writes one text word per cycle. A
// stalled result channel holds the block until the result register is free.
// Only one request is worked on at a time; the result register lets the next
// request in while a result waits. After reset the slot table is swept clear
// at one slot per cycle before the first request is taken.
module name_intern_table_top #(
    parameter int SLOT_COUNT     = nit_pkg::SLOT_COUNT_DEFAULT,
    parameter int MAX_NAME_WORDS = nit_pkg::MAX_NAME_WORDS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    nit_req_if.sink   req,
    nit_rsp_if.source rsp
);

    nit_pkg::ctl_cmd_t ctl_cmd;
    nit_pkg::dp_stat_t dp_stat;

    // sequencer: one request in flight
    nit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_last  (req.word_last),
        .stat     (dp_stat),
        .in_ready (req.ready),
        .cmd      (ctl_cmd)
    );

    // storage, hash unit and result register
    nit_datapath #(
        .SLOT_COUNT     (SLOT_COUNT),
        .MAX_NAME_WORDS (MAX_NAME_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .stat           (dp_stat),
        .in_word        (req.name_word),
        .in_bytes       (req.word_bytes),
        .in_read_id     (req.read_id),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_result_id  (rsp.result_id),
        .out_status     (rsp.status),
        .out_is_new     (rsp.is_new),
        .out_text_word  (rsp.text_word),
        .out_text_bytes (rsp.text_bytes),
        .out_text_last  (rsp.text_last)
    );

endmodule

[rtl/nit_checker.sv]
// Port-level checks for the name intern table, bound to the top level.
// Depends on nit_pkg and name_intern_table_top_defines.svh.
`include "name_intern_table_top_defines.svh"

module nit_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [nit_pkg::ID_W-1:0]      rsp_result_id,
    input logic [nit_pkg::STAT_W-1:0]    rsp_status,
    input logic                          rsp_is_new,
    input logic [nit_pkg::WORD_W-1:0]    rsp_text_word,
    input logic [nit_pkg::BYTES_W-1:0]   rsp_text_bytes,
    input logic                          rsp_text_last
);

    // stalled result holds
    `NIT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_result_id) && $stable(rsp_text_word)
        && $stable(rsp_text_bytes) && $stable(rsp_text_last),
        "result changed while stalled")

    // failed interns report id 0 and are never new
    `NIT_ASSERT_IMP(a_fail_id, rsp_valid && rsp_status != nit_pkg::STATUS_OK,
        rsp_result_id == '0 && !rsp_is_new && rsp_text_last,
        "failed intern with nonzero id")

    // a new entry is a single ok result with a nonzero id
    `NIT_ASSERT_IMP(a_new_ok, rsp_valid && rsp_is_new,
        rsp_status == nit_pkg::STATUS_OK && rsp_result_id != '0 && rsp_text_last
        && rsp_text_bytes == '0,
        "bad new-entry result")

    // only the final word of a read run may be short
    `NIT_ASSERT_IMP(a_full_words, rsp_valid && !rsp_text_last,
        rsp_text_bytes == 4'd8 && rsp_status == nit_pkg::STATUS_OK,
        "short word before end of run")

endmodule

bind name_intern_table_top nit_checker u_nit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_result_id  (rsp.result_id),
    .rsp_status     (rsp.status),
    .rsp_is_new     (rsp.is_new),
    .rsp_text_word  (rsp.text_word),
    .rsp_text_bytes (rsp.text_bytes),
    .rsp_text_last  (rsp.text_last)
);

[dv/name_intern_table_checker.sv]
// Checker for the name intern table: watches both channels, keeps a
// shadow of the table and compares every result. Depends on nit_pkg and the
// channel interfaces.
`timescale 1ns / 100ps
module name_intern_table_checker (
    input logic     clk,
    input logic     rst_n,
    nit_req_if.sink req,
    nit_rsp_if.sink rsp,
    output int      fail_count,
    output int      pending
);

    localparam int SLOTS     = nit_pkg::SLOT_COUNT_DEFAULT;
    localparam int NWORDS    = nit_pkg::MAX_NAME_WORDS_DEFAULT;
    localparam int ENTRY_MAX = SLOTS / 2;
    localparam int BYTE_MAX  = NWORDS * 8;

    typedef struct packed {
        logic [nit_pkg::ID_W-1:0]    id;
        logic [nit_pkg::STAT_W-1:0]  status;
        logic                        is_new;
        logic [nit_pkg::WORD_W-1:0]  word;
        logic [nit_pkg::BYTES_W-1:0] nbytes;
        logic                        last;
    } reply_t;

    logic [nit_pkg::TAG_W-1:0]  slot_tag [SLOTS];
    int unsigned                slot_idp [SLOTS];
    logic [nit_pkg::WORD_W-1:0] stored_text [ENTRY_MAX][NWORDS];
    int unsigned                stored_len [ENTRY_MAX];
    int unsigned                entries;
    logic [nit_pkg::WORD_W-1:0] pend_name [NWORDS];
    int unsigned                pend_bytes;
    bit                         pend_over;
    reply_t                     replies_due[$];

    function automatic logic [63:0] name_hash(int unsigned len);
        logic [63:0] h;
        h = nit_pkg::MIX_SEED ^ 64'(len);
        for (int i = 0; i < (len + 7) / 8 && i < NWORDS; i++)
        begin
            h = (h ^ pend_name[i]) * nit_pkg::MIX_MUL;
            h ^= h >> nit_pkg::ROUND_SHIFT;
        end
        h *= nit_pkg::MIX_MUL;
        return h ^ (h >> nit_pkg::FINAL_SHIFT);
    endfunction

    function automatic void drop_name();
        foreach (pend_name[i]) pend_name[i] = '0;
        pend_bytes = 0;
        pend_over  = 0;
    endfunction

    function automatic void push_intern(int unsigned id, logic [nit_pkg::STAT_W-1:0] st,
                                        bit nw);
        reply_t r;
        r = '{id: nit_pkg::ID_W'(id), status: st, is_new: nw, word: '0, nbytes: '0,
              last: 1'b1};
        replies_due.push_back(r);
        drop_name();
    endfunction

    task automatic predict_request(logic c, logic [63:0] w, logic [3:0] nb_in, logic lst,
                                   logic [nit_pkg::ID_W-1:0] rid);
        int unsigned len, nw, nb, at, tag_id;
        logic [63:0] h;
        logic [nit_pkg::TAG_W-1:0] tag;
        bit hit, empty_found;
        reply_t r;
        if (c == nit_pkg::CMD_READ)
        begin
            len = (rid < entries) ? stored_len[rid] : 0;
            nw = (len + 7) / 8;
            if (nw == 0)
            begin
                r = '{id: rid, status: nit_pkg::STATUS_OK, is_new: 0, word: '0,
                      nbytes: '0, last: 1};
                replies_due.push_back(r);
            end
            for (int i = 0; i < nw; i++)
            begin
                r = '{id: rid, status: nit_pkg::STATUS_OK, is_new: 0,
                      word: stored_text[rid][i],
                      nbytes: (len - i * 8 > 8) ? 4'd8 : nit_pkg::BYTES_W'(len - i * 8),
                      last: (i + 1 == nw)};
                replies_due.push_back(r);
            end
            return;
        end
        nb = (nb_in > 8) ? 8 : nb_in;
        for (int i = 0; i < nb; i++)
        begin
            if (pend_bytes < BYTE_MAX)
            begin
                pend_name[pend_bytes / 8][(pend_bytes % 8) * 8 +: 8] = w[i * 8 +: 8];
                pend_bytes++;
            end
            else
                pend_over = 1;
        end
        if (!lst)
            return;
        if (pend_over)
        begin
            push_intern(0, nit_pkg::STATUS_TOO_LONG, 0);
            return;
        end
        if (pend_bytes == 0)
        begin
            push_intern(0, nit_pkg::STATUS_OK, 0);
            return;
        end
        len = pend_bytes;
        nw = (len + 7) / 8;
        h = name_hash(len);
        tag = h[63:32];
        at = h[31:0] & (SLOTS - 1);
        empty_found = 0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (slot_idp[at] == 0)
            begin
                empty_found = 1;
                break;
            end
            if (slot_tag[at] == tag)
            begin
                tag_id = slot_idp[at] - 1;
                hit = (stored_len[tag_id] == len);
                for (int i = 0; i < nw; i++)
                    if (stored_text[tag_id][i] != pend_name[i]) hit = 0;
                if (hit)
                begin
                    push_intern(tag_id, nit_pkg::STATUS_OK, 0);
                    return;
                end
            end
            at = (at + 1) & (SLOTS - 1);
        end
        if (!empty_found || entries >= ENTRY_MAX)
        begin
            push_intern(0, nit_pkg::STATUS_FULL, 0);
            return;
        end
        foreach (pend_name[i]) stored_text[entries][i] = pend_name[i];
        stored_len[entries] = len;
        slot_tag[at] = tag;
        slot_idp[at] = entries + 1;
        entries++;
        push_intern(entries - 1, nit_pkg::STATUS_OK, 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got, want;
        if (!rst_n)
        begin
            foreach (slot_idp[i]) slot_idp[i] = 0;
            foreach (stored_len[i]) stored_len[i] = 0;
            entries = 1;
            drop_name();
            replies_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // result first: a request taken this edge cannot produce it
            if (rsp.valid && rsp.ready)
            begin
                got = '{id: rsp.result_id, status: rsp.status, is_new: rsp.is_new,
                        word: rsp.text_word, nbytes: rsp.text_bytes, last: rsp.text_last};
                if (replies_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (req.valid && req.ready)
                predict_request(req.cmd, req.name_word, req.word_bytes, req.word_last,
                                req.read_id);
            pending = replies_due.size();
        end
    end

endmodule

[dv/name_intern_table_top_tb.sv]
// Testbench top for the name intern table: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on nit_pkg, the channel
// interfaces, name_intern_table_checker and the block.
`timescale 1ns / 100ps
module name_intern_table_top_tb;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    nit_req_if req ();
    nit_rsp_if rsp ();

    name_intern_table_top dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    name_intern_table_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                                   .fail_count(fail_count), .pending(pending));

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // names already sent, reused so lookups hit existing entries
    logic [63:0] known_word [$];
    logic [3:0]  known_bytes [$];
    bit          rsp_hold;
    int          stall_left;

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // one request, held until taken; gaps before it
    task automatic send(logic c, logic [63:0] w, logic [3:0] nb, logic lst, logic [8:0] rid);
        int gap;
        gap = rsp_hold ? 0 : gap_len();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.cmd        <= c;
        req.name_word  <= w;
        req.word_bytes <= nb;
        req.word_last  <= lst;
        req.read_id    <= rid;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    function automatic logic [63:0] mask_bytes(logic [63:0] w, int nb);
        return (nb >= 8) ? w : (w & ((64'd1 << (nb * 8)) - 1));
    endfunction

    // full name of exactly nwords words; the last word carries tail bytes
    task automatic send_name(int nwords, int tail);
        logic [63:0] w;
        for (int i = 0; i < nwords; i++)
        begin
            w = {$urandom, $urandom};
            if (i == nwords - 1)
            begin
                w = mask_bytes(w, tail);
                send(nit_pkg::CMD_INTERN, w, 4'(tail), 1'b1, 9'($urandom));
            end
            else
                send(nit_pkg::CMD_INTERN, w, 4'd8, 1'b0, 9'($urandom));
        end
        if (nwords == 1 && known_word.size() < 200)
        begin
            known_word.push_back(w);
            known_bytes.push_back(4'(tail));
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // random stall on the result side, mostly short, now and then long
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_hold)
            rsp.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 60) == 0)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= $urandom_range(5, 30);
        end
        else
            rsp.ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        int k, pick;
        bit held;
        rst_n = 1'b0;
        rsp_hold = 0;
        held = 0;
        req.valid = 1'b0;
        req.cmd = nit_pkg::CMD_INTERN;
        req.name_word = '0;
        req.word_bytes = '0;
        req.word_last = 1'b0;
        req.read_id = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty name, extremes, overlong, reads
        send(nit_pkg::CMD_INTERN, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 9'd0);
        send(nit_pkg::CMD_READ, '0, '0, 1'b0, 9'd0);
        send(nit_pkg::CMD_READ, '0, '0, 1'b0, 9'd511);
        send(nit_pkg::CMD_INTERN, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 9'd511);
        send(nit_pkg::CMD_INTERN, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 9'd0);
        send(nit_pkg::CMD_INTERN, 64'h0000_0000_0000_0041, 4'd1, 1'b1, 9'd0);
        send(nit_pkg::CMD_INTERN, 64'h0000_0000_0000_0041, 4'd1, 1'b1, 9'd0);
        send(nit_pkg::CMD_INTERN, 64'h1234, 4'd0, 1'b0, 9'd0);
        send(nit_pkg::CMD_INTERN, 64'h0000_0000_0000_0041, 4'd1, 1'b1, 9'd0);
        send(nit_pkg::CMD_READ, '0, '0, 1'b0, 9'd1);
        send(nit_pkg::CMD_READ, '0, '0, 1'b0, 9'd2);
        send_name(8, 8);
        send(nit_pkg::CMD_READ, '0, '0, 1'b0, 9'd3);
        for (int i = 0; i < 9; i++)
            send(nit_pkg::CMD_INTERN, {$urandom, $urandom}, 4'd8, i == 8, '0);
        send(nit_pkg::CMD_INTERN, 64'h55, 4'd1, 1'b0, '0);
        send(nit_pkg::CMD_READ, '0, '0, 1'b0, 9'd2);
        send(nit_pkg::CMD_INTERN, 64'h66, 4'd1, 1'b1, '0);

        // hold the sender until all results are back
        drain();

        // random: mostly whole names, some repeats, reads and noise
        k = 0;
        while (k < 340)
        begin
            pick = $urandom_range(0, 99);
            if (k >= 170 && !held)
            begin
                held = 1;
                rsp_hold = 1;
                drain();
                rsp_hold = 0;
            end
            if (pick < 45)
            begin
                pick = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
                send_name(pick, $urandom_range(1, 8));
                k += pick;
            end
            else if (pick < 65 && known_word.size() > 0)
            begin
                pick = $urandom_range(0, known_word.size() - 1);
                send(nit_pkg::CMD_INTERN, known_word[pick], known_bytes[pick], 1'b1,
                     9'($urandom));
                k++;
            end
            else if (pick < 85)
            begin
                send(nit_pkg::CMD_READ, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                     ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40)));
                k++;
            end
            else
            begin
                send(nit_pkg::CMD_INTERN, {$urandom, $urandom}, 4'($urandom), 1'($urandom),
                     9'($urandom));
                k++;
            end
        end
        send(nit_pkg::CMD_INTERN, '0, 4'd0, 1'b1, '0);

        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASS name_intern_table_top");
        else
            $display("FAIL name_intern_table_top");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL name_intern_table_top");
        $finish;
    end

endmodule
